@@ design/lfcr_pkg.sv @@
// shared types, constants and helper function of the line frame checker router
package lfcr_pkg;

   // character codes, destination saturation and reset destination count
   localparam logic [7:0] NL_CHAR    = 8'd10;
   localparam logic [7:0] DIGIT_LO   = 8'd48;
   localparam logic [7:0] DIGIT_HI   = 8'd57;
   localparam logic [4:0] DEST_SAT   = 5'd31;
   localparam logic [3:0] DEST_COUNT_RESET = 4'd5;

   // configuration register indexes
   localparam logic [0:0] REG_DEST_COUNT = 1'b0;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND_BYTE,
      ST_SEND_NL
   } lfcr_state_type;

   // what a finished frame turns into
   typedef enum logic [1:0] {
      FRAME_DROP,
      FRAME_NL_ONLY,
      FRAME_BYTES
   } frame_kind_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic advance;
      logic sel_nl;
   } lfcr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic           is_nl;
      frame_kind_type kind;
      logic           rd_done;
   } lfcr_sts_type;

   // hex digit decode: bit 4 flags a legal digit, bits 3:0 its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c > 8'd47 && c < 8'd58) begin
         res = {1'b1, 4'(c - 8'd48)};
      end else if (c > 8'd64 && c < 8'd71) begin
         res = {1'b1, 4'(c - 8'd55)};
      end else if (c > 8'd96 && c < 8'd103) begin
         res = {1'b1, 4'(c - 8'd87)};
      end
      return res;
   endfunction

endpackage

@@ design/lfcr_ctrl.sv @@
// controller state machine: collects beats, then sequences the replay of a frame unless it is dropped
module lfcr_ctrl import lfcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_out_last,
   output lfcr_cmd_type cmd,
   input  lfcr_sts_type sts
);

   lfcr_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      rsp_out_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && sts.is_nl) begin
               case (sts.kind)
                  FRAME_BYTES:   state_in = ST_READ;
                  FRAME_NL_ONLY: state_in = ST_SEND_NL;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SEND_BYTE;
         end
         ST_SEND_BYTE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.advance = 1'b1;
               state_in    = sts.rd_done ? ST_SEND_NL : ST_READ;
            end
         end
         ST_SEND_NL: begin
            rsp_valid    = 1'b1;
            rsp_out_last = 1'b1;
            cmd.sel_nl   = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/lfcr_dp.sv @@
// datapath: line store, frame checks, replay pointers and the config register
module lfcr_dp import lfcr_pkg::*; #(
   parameter int LINE_MAX = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   req_in_byte,
   output logic [7:0]   rsp_out_byte,
   output logic [3:0]   rsp_out_dest,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   input  lfcr_cmd_type cmd,
   output lfcr_sts_type sts
);

   localparam int LW = $clog2(LINE_MAX + 1);
   localparam int AW = $clog2(LINE_MAX);

   logic [7:0]    store_mem [LINE_MAX];
   logic [LW-1:0] len_ff, len_in;
   logic [4:0]    dest_ff, dest_in;
   logic          ended_ff, ended_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    last_ff;
   logic [LW-1:0] rd_ptr_ff, end_ff;
   logic [3:0]    tag_ff;
   logic [7:0]    rd_data_ff;
   logic [3:0]    dest_count_ff;

   logic          store_en;
   logic          is_digit;
   logic [8:0]    dest_acc;
   logic [4:0]    hex;
   logic [7:0]    len_m2;
   logic          frame_ok;
   logic          in_range;
   logic [LW-1:0] start_pos, end_pos;
   logic          cfg_wr;

   // per-byte line bookkeeping
   always_comb begin
      store_en = (len_ff < LW'(LINE_MAX));
      is_digit = (req_in_byte >= DIGIT_LO) && (req_in_byte <= DIGIT_HI);
      dest_acc = 9'(dest_ff) * 9'd10 + 9'(req_in_byte - DIGIT_LO);
      len_in   = len_ff;
      dest_in  = dest_ff;
      ended_in = ended_ff;
      ovf_in   = ovf_ff;
      if (store_en) begin
         len_in = len_ff + LW'(1);
      end else begin
         ovf_in = 1'b1;
      end
      if (!ended_ff) begin
         if (is_digit) begin
            dest_in = (dest_acc > 9'(DEST_SAT)) ? DEST_SAT : dest_acc[4:0];
         end else begin
            ended_in = 1'b1;
         end
      end
   end

   // frame check at the newline
   always_comb begin
      hex      = hex_decode(last_ff);
      len_m2   = 8'(len_ff) - 8'd2;
      frame_ok = !ovf_ff && (len_ff >= LW'(2)) && hex[4] && (hex[3:0] == len_m2[3:0]);
      in_range = (dest_ff >= 5'd1) && (dest_ff <= 5'(dest_count_ff));
      if (frame_ok) begin
         start_pos = LW'(1);
         end_pos   = len_ff - LW'(1);
      end else begin
         start_pos = '0;
         end_pos   = len_ff;
      end
      sts.is_nl   = (req_in_byte == NL_CHAR);
      sts.rd_done = ((rd_ptr_ff + LW'(1)) == end_ff);
      if (frame_ok && !in_range) begin
         sts.kind = FRAME_DROP;
      end else if (start_pos < end_pos) begin
         sts.kind = FRAME_BYTES;
      end else begin
         sts.kind = FRAME_NL_ONLY;
      end
   end

   // line state registers, cleared after each newline
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         dest_ff  <= '0;
         ended_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (cmd.accept) begin
         if (sts.is_nl) begin
            len_ff   <= '0;
            dest_ff  <= '0;
            ended_ff <= 1'b0;
            ovf_ff   <= 1'b0;
         end else begin
            len_ff   <= len_in;
            dest_ff  <= dest_in;
            ended_ff <= ended_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   // line store write and replay read
   always_ff @(posedge clock) begin
      if (cmd.accept && !sts.is_nl && store_en) begin
         store_mem[len_ff[AW-1:0]] <= req_in_byte;
         last_ff                   <= req_in_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_ptr_ff[AW-1:0]];
      end
   end

   // replay window and tag, loaded at the newline
   always_ff @(posedge clock) begin
      if (cmd.accept && sts.is_nl) begin
         rd_ptr_ff <= start_pos;
         end_ff    <= end_pos;
         tag_ff    <= frame_ok ? dest_ff[3:0] : 4'd0;
      end else if (cmd.advance) begin
         rd_ptr_ff <= rd_ptr_ff + LW'(1);
      end
   end

   assign rsp_out_byte = cmd.sel_nl ? NL_CHAR : rd_data_ff;
   assign rsp_out_dest = tag_ff;

   // configuration register
   assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_DEST_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_count_ff <= DEST_COUNT_RESET;
      end else if (cfg_wr) begin
         dest_count_ff <= pwdata[3:0];
      end
   end

   assign prdata = (paddr[2:2] == REG_DEST_COUNT) ? {28'd0, dest_count_ff} : 32'd0;

endmodule

@@ design/line_frame_checker_router.sv @@
// top level of the line frame checker router
// Bytes of newline-ended text frames enter on req_ at one beat per cycle while
// req_stall is low and are kept in the line store (up to LINE_MAX per line). No
// beat leaves while a line is collected. At the newline the frame is checked
// and, while its output is replayed, req_stall stays high: each emitted byte
// is first read into a register from the line store and then offered on the
// output, held there while rsp_stall is high, and the closing newline follows
// the last byte. A dropped frame does not stall the input. dest_count sits at
// byte address 0 of the register port, reset value 5.
module line_frame_checker_router import lfcr_pkg::*; #(
   parameter int LINE_MAX = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_out_dest,
   output logic        rsp_out_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   lfcr_cmd_type cmd;
   lfcr_sts_type sts;

   assign pready = 1'b1;

   // sequencer
   lfcr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_last (rsp_out_last),
      .cmd          (cmd),
      .sts          (sts)
   );

   // storage and checks
   lfcr_dp #(
      .LINE_MAX (LINE_MAX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_in_byte  (req_in_byte),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_dest (rsp_out_dest),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule

@@ design/lfcr_checker.sv @@
// port-level checks of the line frame checker router and their binding
module lfcr_checker import lfcr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [3:0] rsp_out_dest,
   input logic       rsp_out_last
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_dest) && $stable(rsp_out_last))
      else $error("stalled result beat changed");

   // input is held off while a frame is replayed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during replay");

   // the closing beat is a newline
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> rsp_out_byte == NL_CHAR)
      else $error("last beat is not a newline");

   // after the closing beat the block goes back to collecting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_out_last |=> !rsp_valid && !req_stall)
      else $error("no return to collecting after last beat");

   // an ordinary byte produces no output
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_in_byte != NL_CHAR |=> !rsp_valid)
      else $error("output after ordinary byte");

endmodule

bind line_frame_checker_router lfcr_checker u_lfcr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_in_byte  (req_in_byte),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_dest (rsp_out_dest),
   .rsp_out_last (rsp_out_last)
);

@@ tb/frame_route_checker.sv @@
// checker for the line frame checker router: predicts emitted beats and compares them
module frame_route_checker import lfcr_pkg::*; #(
   parameter int LINE_MAX = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic [3:0]  rsp_out_dest,
   input  logic        rsp_out_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          beats_outstanding,
   output int          mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic [3:0] dest;
      logic       last;
   } emit_beat_type;

   // predicted line state
   logic [7:0] line_buf [64];
   int         line_len;
   int         dest_acc;
   bit         digits_done;
   bit         line_overflow;
   logic [3:0] dest_limit;

   emit_beat_type expected_emits [$];
   int            fail_total;

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
   endfunction

   task automatic push_emit(input logic [7:0] d, input logic [3:0] dst, input logic lst);
      emit_beat_type b;
      b.data = d;
      b.dest = dst;
      b.last = lst;
      expected_emits.push_back(b);
   endtask

   task automatic clear_line();
      line_len = 0;
      dest_acc = 0;
      digits_done = 1'b0;
      line_overflow = 1'b0;
   endtask

   // store one character, or judge the frame at the newline
   task automatic route_char(input logic [7:0] c);
      int  v;
      int  h;
      bit  frame_ok;
      if (c != NL_CHAR) begin
         if (line_len < LINE_MAX) begin
            line_buf[line_len] = c;
            line_len++;
         end else begin
            line_overflow = 1'b1;
         end
         if (!digits_done) begin
            if (c >= DIGIT_LO && c <= DIGIT_HI) begin
               v = dest_acc * 10 + (int'(c) - 48);
               dest_acc = (v > int'(DEST_SAT)) ? int'(DEST_SAT) : v;
            end else begin
               digits_done = 1'b1;
            end
         end
      end else begin
         frame_ok = 1'b0;
         if (!line_overflow && line_len >= 2) begin
            h = hex_value(line_buf[line_len - 1]);
            frame_ok = (h >= 0) && (h == ((line_len - 2) % 16));
         end
         if (!frame_ok) begin
            // reject stream gets the whole stored line
            for (int i = 0; i < line_len; i++) push_emit(line_buf[i], 4'd0, 1'b0);
            push_emit(NL_CHAR, 4'd0, 1'b1);
         end else if (dest_acc >= 1 && dest_acc <= int'(dest_limit)) begin
            // payload without the first and checksum characters
            for (int i = 1; i + 1 < line_len; i++) begin
               push_emit(line_buf[i], 4'(dest_acc), 1'b0);
            end
            push_emit(NL_CHAR, 4'(dest_acc), 1'b1);
         end
         clear_line();
      end
   endtask

   // watch both channels and the register port at every edge
   always @(posedge clock) begin
      emit_beat_type e;
      if (reset) begin
         clear_line();
         dest_limit = DEST_COUNT_RESET;
         expected_emits.delete();
         fail_total = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_DEST_COUNT)) begin
            dest_limit = pwdata[3:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_emits.size() == 0) begin
               if (fail_total < 10) begin
                  $display("unexpected beat: byte %h dest %0d last %b",
                           rsp_out_byte, rsp_out_dest, rsp_out_last);
               end
               fail_total++;
            end else begin
               e = expected_emits.pop_front();
               if (rsp_out_byte !== e.data || rsp_out_dest !== e.dest
                   || rsp_out_last !== e.last) begin
                  if (fail_total < 10) begin
                     $display({"beat mismatch: expected byte %h dest %0d last %b,",
                               " got byte %h dest %0d last %b"},
                              e.data, e.dest, e.last,
                              rsp_out_byte, rsp_out_dest, rsp_out_last);
                  end
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) route_char(req_in_byte);
      end
      beats_outstanding <= expected_emits.size();
      mismatch_count <= fail_total;
   end

endmodule

@@ tb/line_frame_checker_router_test.sv @@
// top of the line frame checker router testbench: clock, reset, stimulus and verdict
module line_frame_checker_router_test import lfcr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX = 63;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [3:0]  rsp_out_dest;
   logic        rsp_out_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int          beats_outstanding;
   int          mismatch_count;
   int          gap_pct = 0;
   int          stall_pct = 0;
   logic        holdoff_req = 1'b0;
   logic [7:0]  line_chars [$];

   line_frame_checker_router #(.LINE_MAX(LINE_MAX)) dut (.*);

   frame_route_checker #(.LINE_MAX(LINE_MAX)) checker_i (.*);

   always #4 clock = ~clock;

   // watchdog
   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   // receiver: random stalls plus one long hold-off
   int holdoff_left = 0;
   bit holdoff_used = 1'b0;
   always @(posedge clock) begin
      if (holdoff_req && !holdoff_used) begin
         holdoff_left = 600;
         holdoff_used = 1'b1;
      end
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic logic [7:0] any_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == NL_CHAR);
      return c;
   endfunction

   function automatic logic [7:0] non_digit_char();
      logic [7:0] c;
      do c = any_char(); while (c >= DIGIT_LO && c <= DIGIT_HI);
      return c;
   endfunction

   // checksum character, upper or lower case for a..f
   function automatic logic [7:0] hex_char(input int h);
      if (h < 10) return 8'(48 + h);
      return ($urandom_range(0, 1) != 0) ? 8'(55 + h) : 8'(87 + h);
   endfunction

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // drain all expected beats, then give the block time to finish a dropped frame
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_outstanding != 0) @(posedge clock);
      repeat (2 * LINE_MAX + 20) @(posedge clock);
   endtask

   task automatic write_dest_count(input logic [3:0] v);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 3'(4 * REG_DEST_COUNT);
      pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // one random frame: mostly well formed, some bad checksums, short, overlong or noise
   task automatic make_frame();
      int kind;
      int n;
      int want;
      int body_max;
      line_chars.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         // destination digits
         if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(0, 16);
            if (n >= 10) line_chars.push_back(8'(48 + n / 10));
            line_chars.push_back(8'(48 + n % 10));
         end else begin
            repeat ($urandom_range(0, 3)) line_chars.push_back(8'(48 + $urandom_range(0, 9)));
         end
         body_max = ($urandom_range(0, 19) == 0) ? 62 - line_chars.size() : 12;
         n = $urandom_range(0, body_max);
         for (int i = 0; i < n; i++) begin
            if (i == 0) line_chars.push_back(non_digit_char());
            else if ($urandom_range(0, 1) != 0) line_chars.push_back(8'($urandom_range(32, 126)));
            else line_chars.push_back(any_char());
         end
         want = (line_chars.size() - 1) & 15;
         if (kind < 55) begin
            line_chars.push_back(hex_char(want));
         end else if ($urandom_range(0, 1) != 0) begin
            line_chars.push_back(hex_char((want + $urandom_range(1, 15)) & 15));
         end else if ($urandom_range(0, 1) != 0) begin
            line_chars.push_back(8'($urandom_range(103, 255)));
         end else begin
            line_chars.push_back(8'($urandom_range(71, 96)));
         end
      end else if (kind < 78) begin
         repeat ($urandom_range(0, 1)) line_chars.push_back(any_char());
      end else if (kind < 85) begin
         repeat ($urandom_range(62, 80)) line_chars.push_back(any_char());
      end else begin
         repeat ($urandom_range(1, 15)) line_chars.push_back(8'($urandom_range(0, 255)));
      end
      line_chars.push_back(NL_CHAR);
   endtask

   initial begin
      logic [3:0] phase_limit [4];
      int         sent;
      phase_limit[0] = 4'd15;
      phase_limit[1] = 4'd1;
      phase_limit[2] = 4'($urandom_range(2, 14));
      phase_limit[3] = 4'd9;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames with the reset destination count
      send_char(NL_CHAR);
      send_text("5\n");
      send_text("3xy2\n");
      send_text("4ab3\n");
      send_text("2q");
      send_char(8'hFF);
      send_text("g\n");
      send_text("9z1\n");
      send_char(8'h00);
      send_text("b1\n");
      settle();
      // two-character valid line: newline only on its destination
      write_dest_count(4'd15);
      send_text("10\n");
      settle();

      // random phases with different idling and destination counts
      for (int phase = 0; phase < 4; phase++) begin
         write_dest_count(phase_limit[phase]);
         case (phase)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 45; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 45; end
            default: begin gap_pct = 26; stall_pct = 26; end
         endcase
         sent = 0;
         while (sent < 110) begin
            make_frame();
            if (phase == 0 && sent > 30 && !holdoff_req) holdoff_req <= 1'b1;
            foreach (line_chars[i]) send_char(line_chars[i]);
            sent += line_chars.size();
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
